>>> rtl/wsenc_pkg.sv
// Package: shared types, register indexes and the brightness gain table.
`timescale 1ns / 1ps
package wsenc_pkg;

  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned MaxSlots     = 50;
  localparam int unsigned CntW         = 6;
  localparam int unsigned LevelMin     = 1;
  localparam int unsigned LevelMax     = 44;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_ZERO_DUTY  = 2'd1,
    REG_ONE_DUTY   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       last;
  } slot_out_t;

  // Word handed from the scaling stages to the serializer
  typedef struct packed {
    logic                    op;
    logic [BitsPerPixel-1:0] word;
  } ser_load_t;

  // tan(k degrees) in Q0.16, k = 0..44
  localparam logic [15:0] GainQ16 [0:LevelMax] = '{
    16'd0,
    16'd1144,  16'd2289,  16'd3435,  16'd4583,  16'd5734,
    16'd6888,  16'd8047,  16'd9210,  16'd10380, 16'd11556,
    16'd12739, 16'd13930, 16'd15130, 16'd16340, 16'd17560,
    16'd18792, 16'd20036, 16'd21294, 16'd22566, 16'd23853,
    16'd25157, 16'd26478, 16'd27818, 16'd29179, 16'd30560,
    16'd31964, 16'd33392, 16'd34846, 16'd36327, 16'd37837,
    16'd39378, 16'd40951, 16'd42560, 16'd44205, 16'd45889,
    16'd47615, 16'd49385, 16'd51202, 16'd53070, 16'd54991,
    16'd56970, 16'd59009, 16'd61113, 16'd63287
  };

  // Clamp the level to 1..44 and look up its gain
  function automatic logic [15:0] gain_lookup(input logic [5:0] level);
    logic [5:0] lvl;
    lvl = level;
    if (lvl < 6'(LevelMin)) lvl = 6'(LevelMin);
    if (lvl > 6'(LevelMax)) lvl = 6'(LevelMax);
    return GainQ16[lvl];
  endfunction

endpackage

>>> rtl/wsenc_serializer.sv
// Slot serializer: turns one color word or frame end into a run of duty slots.
`timescale 1ns / 1ps
module wsenc_serializer #(
  parameter int unsigned RstSlots = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_valid_i,
  input  wsenc_pkg::ser_load_t load_i,
  output logic                 load_ready_o,
  input  logic [7:0]           zero_duty_i,
  input  logic [7:0]           one_duty_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wsenc_pkg::slot_out_t out_data_o
);

  localparam int unsigned W = wsenc_pkg::BitsPerPixel;

  logic                        ser_v_q, ser_v_d;
  logic                        ser_op_q, ser_op_d;
  logic [W-1:0]                word_q, word_d;
  logic [wsenc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                        out_v_q, out_v_d;
  wsenc_pkg::slot_out_t        out_q, out_d;

  logic out_free, emit, emit_last, take;

  assign out_free  = !out_v_q || !out_stall_i;
  assign emit      = ser_v_q && out_free;
  assign emit_last = (cnt_q == wsenc_pkg::CntW'(1));
  assign take      = !ser_v_q || (emit && emit_last);
  assign load_ready_o = take;

  // Shift one slot out per cycle while the output is not stalled, reload on the final slot
  always_comb begin
    ser_v_d  = ser_v_q;
    ser_op_d = ser_op_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    if (out_free) begin
      out_v_d = emit;
    end
    if (emit) begin
      out_d.duty = ser_op_q ? 8'd0 : (word_q[W-1] ? one_duty_i : zero_duty_i);
      out_d.last = emit_last;
      word_d     = {word_q[W-2:0], 1'b0};
      cnt_d      = cnt_q - wsenc_pkg::CntW'(1);
      if (emit_last) ser_v_d = 1'b0;
    end
    if (take && load_valid_i) begin
      ser_v_d  = 1'b1;
      ser_op_d = load_i.op;
      word_d   = load_i.word;
      cnt_d    = load_i.op ? wsenc_pkg::CntW'(RstSlots) : wsenc_pkg::CntW'(W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      ser_v_q <= ser_v_d;
      out_v_q <= out_v_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ser_op_q <= ser_op_d;
    word_q   <= word_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/ws2812_pwm_slot_encoder_top.sv
// Top level: configuration registers, gain lookup and scaling stages, serializer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | in        | in_valid_i/in_stall_o | pixel_in_t: op, red, green, blue
//  out     | out       | out_valid_o/out_stall_i| slot_out_t: duty, last
//  cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A pixel gives 24 slots at the output, an end-of-frame item min(RESET_SLOTS, 50);
// the serializer emits one slot per cycle while the output is not stalled. An item
// passes the gain stage, which loads at the accepting edge, then the scaling stage
// and the serializer; its first slot is then taken from the output register.
// Reset clears all valid bits and loads brightness 20, duties 22 and 44.
// A stall on the output backs up stage by stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
module ws2812_pwm_slot_encoder_top #(
  parameter int unsigned RESET_SLOTS = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wsenc_pkg::pixel_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wsenc_pkg::slot_out_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int unsigned RstSlots =
    (RESET_SLOTS > wsenc_pkg::MaxSlots) ? wsenc_pkg::MaxSlots : RESET_SLOTS;

  // Configuration registers
  logic [5:0] bright_q;
  logic [7:0] zero_duty_q, one_duty_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= 6'd20;
      zero_duty_q <= 8'd22;
      one_duty_q  <= 8'd44;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wsenc_pkg::REG_BRIGHTNESS: bright_q    <= cfg_data_i[5:0];
        wsenc_pkg::REG_ZERO_DUTY:  zero_duty_q <= cfg_data_i;
        wsenc_pkg::REG_ONE_DUTY:   one_duty_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_v_q, s2_v_q;
  logic s1_free, s2_free, ser_ready, in_acc;

  assign s2_free    = !s2_v_q || ser_ready;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 1: capture the item and its gain
  wsenc_pkg::pixel_in_t s1_pix_q;
  logic [15:0]          s1_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= in_data_i;
      s1_gain_q <= wsenc_pkg::gain_lookup(bright_q);
    end
  end

  // Stage 2: scale each channel, keep the integer part, order as G, R, B
  logic [23:0]          prod_r, prod_g, prod_b;
  wsenc_pkg::ser_load_t s2_q;

  assign prod_r = 24'(s1_pix_q.red)   * 24'(s1_gain_q);
  assign prod_g = 24'(s1_pix_q.green) * 24'(s1_gain_q);
  assign prod_b = 24'(s1_pix_q.blue)  * 24'(s1_gain_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_v_q) begin
      s2_q.op   <= s1_pix_q.op;
      s2_q.word <= {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
    end
  end

  // Stage 3 and output register
  wsenc_serializer #(
    .RstSlots(RstSlots)
  ) u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s2_v_q),
    .load_i       (s2_q),
    .load_ready_o (ser_ready),
    .zero_duty_i  (zero_duty_q),
    .one_duty_i   (one_duty_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> rtl/wsenc_checker.sv
// Checker: port-level properties of the slot encoder, bound to the top level.
`timescale 1ns / 1ps
module wsenc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input wsenc_pkg::slot_out_t out_data_o
);

  // Hold a stalled slot
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output slot changed");

  // A run of slots has no gaps until its last slot
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a slot run");

  // Come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty after reset");

endmodule

bind ws2812_pwm_slot_encoder_top wsenc_checker u_wsenc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
